// File: rtl/fixed_block_free_list_allocator_core_macros.svh
// Assertion macros shared by the free list allocator RTL.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FBFLA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("free list allocator check failed");

// Next-cycle implication, disabled during reset.
`define FBFLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("free list allocator check failed");

`endif

// File: rtl/fbfla_pkg.sv
// Package with payload types, widths and codes of the free list allocator.
package fbfla_pkg;

   localparam int POOL_DEPTH_DEFAULT = 1024;
   localparam int POOL_RESET         = 1024;

   localparam int BLK_IDX_W = 10;
   localparam int CNT_W     = 11;
   localparam int STATUS_W  = 3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FREED      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE_ALLOC = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd4;

   typedef struct packed {
      logic                 req_type;
      logic [BLK_IDX_W-1:0] block_index;
   } req_payload_type;

   typedef struct packed {
      logic [BLK_IDX_W-1:0] granted_index;
      logic [STATUS_W-1:0]  status;
      logic [CNT_W-1:0]     used_blocks;
   } rsp_payload_type;

endpackage

// File: rtl/fixed_block_free_list_allocator_core.sv
// Fixed-size block pool allocator built around a linked free list in one memory.
//
//   channel   direction  handshake                payload
//   req_      in         req_valid / req_stall    req_data   (req_type, block_index)
//   rsp_      out        rsp_valid / rsp_stall    rsp_data   (granted_index, status, used_blocks)
//   csr_      in         csr_wr_en                csr_wr_data (pool_blocks)
//
// At accept, a request is registered and the head block's link is read from the link
// memory; in S_EXEC the pop or push is applied and the result register is loaded.
// After reset and after every pool size write, a sweep rewrites the descending chain
// over all POOL_DEPTH entries; no request is accepted while it runs.
// A result waiting on rsp_stall lets one further request in; that request then holds
// in S_EXEC until the result register frees up.
module fixed_block_free_list_allocator_core #(
   parameter int POOL_DEPTH = fbfla_pkg::POOL_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fbfla_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fbfla_pkg::rsp_payload_type rsp_data,
   input  logic                       csr_wr_en,
   input  logic [fbfla_pkg::CNT_W-1:0] csr_wr_data
);
   import fbfla_pkg::*;

   localparam int LINK_W   = $clog2(POOL_DEPTH);
   localparam int EXT_W    = (LINK_W > BLK_IDX_W) ? LINK_W : BLK_IDX_W;
   localparam int POOL_MAX = (POOL_DEPTH < 2047) ? POOL_DEPTH : 2047;
   localparam int POOL_RST = (POOL_RESET < POOL_MAX) ? POOL_RESET : POOL_MAX;

   localparam logic [1:0] S_SWEEP = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [LINK_W-1:0]     sweep_ff, sweep_in;
   logic [CNT_W-1:0]      pool_ff, pool_in;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   req_payload_type       req_ff, req_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [LINK_W-1:0]     link_ff [POOL_DEPTH];
   logic [LINK_W-1:0]     rd_data_ff;
   logic                  mem_re;
   logic                  mem_we;
   logic [LINK_W-1:0]     mem_waddr;
   logic [LINK_W-1:0]     mem_wdata;

   logic                  req_accept;
   logic                  slot_free;
   logic                  exec_fire;
   logic                  exhausted;
   logic                  range_bad;
   logic [CNT_W-1:0]      pool_clamped;
   logic [EXT_W-1:0]      head_ext;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_fire  = (state_ff == S_EXEC) && slot_free;
   assign exhausted  = (count_ff >= pool_ff);
   assign range_bad  = (CNT_W'(req_ff.block_index) >= pool_ff);
   assign head_ext   = EXT_W'(head_ff);
   assign mem_re     = req_accept;

   always_comb begin
      if (csr_wr_data == '0) begin
         pool_clamped = CNT_W'(1);
      end else if (csr_wr_data > CNT_W'(POOL_MAX)) begin
         pool_clamped = CNT_W'(POOL_MAX);
      end else begin
         pool_clamped = csr_wr_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      pool_in      = pool_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = (sweep_ff == '0) ? '0 : sweep_ff - LINK_W'(1);

      case (state_ff)
         S_SWEEP: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + LINK_W'(1);
            if (sweep_ff == LINK_W'(POOL_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in                  = S_IDLE;
               rsp_valid_in              = 1'b1;
               rsp_data_in.granted_index = '0;
               if (req_ff.req_type == REQ_ALLOC) begin
                  if (exhausted) begin
                     rsp_data_in.status = ST_EXHAUSTED;
                  end else begin
                     rsp_data_in.granted_index = head_ext[BLK_IDX_W-1:0];
                     rsp_data_in.status        = ST_GRANTED;
                     head_in                   = rd_data_ff;
                     count_in                  = count_ff + CNT_W'(1);
                  end
               end else begin
                  if (range_bad) begin
                     rsp_data_in.status = ST_RANGE;
                  end else if (count_ff == '0) begin
                     rsp_data_in.status = ST_NONE_ALLOC;
                  end else begin
                     rsp_data_in.status = ST_FREED;
                     mem_we             = 1'b1;
                     mem_waddr          = LINK_W'(req_ff.block_index);
                     mem_wdata          = head_ff;
                     head_in            = LINK_W'(req_ff.block_index);
                     count_in           = count_ff - CNT_W'(1);
                  end
               end
               rsp_data_in.used_blocks = count_in;
            end
         end
         default: begin
            state_in = S_SWEEP;
            sweep_in = '0;
         end
      endcase

      // A pool size write restarts the pool from scratch.
      if (csr_wr_en) begin
         pool_in  = pool_clamped;
         head_in  = LINK_W'(pool_clamped - CNT_W'(1));
         count_in = '0;
         sweep_in = '0;
         state_in = S_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         pool_ff      <= CNT_W'(POOL_RST);
         head_ff      <= LINK_W'(POOL_RST - 1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pool_ff      <= pool_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The head's link is read at accept; any write to the memory lands in S_EXEC or in the
   // sweep, before the next accept, so the next read always sees it.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= link_ff[head_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "fixed_block_free_list_allocator_core_macros.svh"

   `FBFLA_ASSERT_SAME(a_count_in_pool, clock, reset, 1'b1, count_ff <= pool_ff)
   `FBFLA_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_accept && !csr_wr_en, state_ff == S_EXEC)
   `FBFLA_ASSERT_SAME(a_grant_counts, clock, reset, rsp_valid && rsp_data.status == ST_GRANTED, rsp_data.used_blocks != '0)
   `FBFLA_ASSERT_SAME(a_none_alloc_zero, clock, reset, rsp_valid && rsp_data.status == ST_NONE_ALLOC, rsp_data.used_blocks == '0)

endmodule
